@@ rtl/dot_star_regex_matcher_core_assert.svh @@
// Assertion helpers shared by the matcher modules.
`ifndef DOT_STAR_REGEX_MATCHER_CORE_ASSERT_SVH
`define DOT_STAR_REGEX_MATCHER_CORE_ASSERT_SVH

// Check on every rising edge of clk, idle while arst_n is low.
`define DSRM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check on every rising edge of clk, reset included.
`define DSRM_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/dsrm_pkg.sv @@
package dsrm_pkg;

	typedef enum logic [1:0] {
		CMD_CLEAR   = 2'd0,
		CMD_APPEND  = 2'd1,
		CMD_RESTART = 2'd2,
		CMD_TEXT    = 2'd3
	} cmd_t;

	localparam logic [7:0] CH_ANY  = 8'h2E;
	localparam logic [7:0] CH_STAR = 8'h2A;

	localparam int COUNT_OUT_W = 5;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic prep;
		logic step;
		logic finish;
	} dsrm_ctl_t;

	// datapath to controller
	typedef struct packed {
		logic last_step;
	} dsrm_status_t;

endpackage

@@ rtl/dsrm_ctrl.sv @@
module dsrm_ctrl
	import dsrm_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	output logic         m_tvalid,
	input  logic         m_tready,
	input  dsrm_status_t status,
	output dsrm_ctl_t    ctl
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PREP,
		ST_CLOSE,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic   ready_q;
	logic   mvalid_q;
	logic   out_free;

	assign s_tready = ready_q;
	assign m_tvalid = mvalid_q;
	assign out_free = !mvalid_q || m_tready;

	always_comb begin
		ctl.accept = (state_q == ST_IDLE) && ready_q && s_tvalid;
		ctl.prep   = (state_q == ST_PREP);
		ctl.step   = (state_q == ST_CLOSE);
		ctl.finish = (state_q == ST_FINISH) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ready_q  <= 1'b1;
			mvalid_q <= 1'b0;
		end else begin
			if (ctl.finish) begin
				mvalid_q <= 1'b1;
			end else if (m_tready) begin
				mvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (ctl.accept) begin
						ready_q <= 1'b0;
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					state_q <= ST_CLOSE;
				end
				ST_CLOSE: begin
					if (status.last_step) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					// hold the result until the output register frees up
					if (out_free) begin
						ready_q  <= 1'b1;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					ready_q <= 1'b1;
				end
			endcase
		end
	end

	`include "dot_star_regex_matcher_core_assert.svh"

	`DSRM_ASSERT(a_one_item_in_work, (s_tvalid && s_tready) |=> !s_tready, "second beat taken while an item is in work")
	`DSRM_ASSERT(a_no_result_overwrite, ctl.finish |-> (!mvalid_q || m_tready), "pending result overwritten")
	`DSRM_ASSERT(a_step_while_busy, (ctl.step || ctl.prep) |-> !s_tready, "closure runs while input is open")

endmodule

@@ rtl/dsrm_datapath.sv @@
module dsrm_datapath
	import dsrm_pkg::*;
#(
	parameter int MAX_ELEMENTS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  dsrm_ctl_t              ctl,
	input  logic [1:0]             in_cmd,
	input  logic [7:0]             in_byte,
	output dsrm_status_t           status,
	output logic                   full_match,
	output logic                   pattern_overflow,
	output logic [COUNT_OUT_W-1:0] element_count_out
);

	localparam int W     = MAX_ELEMENTS + 1;
	localparam int CW    = $clog2(MAX_ELEMENTS + 1);
	localparam int IW    = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
	localparam int NSTEP = CW;
	localparam int XW    = (CW > COUNT_OUT_W) ? CW : COUNT_OUT_W;

	logic [7:0]       chars_q [MAX_ELEMENTS];
	logic             star_q  [MAX_ELEMENTS];
	logic [CW-1:0]    cnt_q;
	logic [W-1:0]     vec_q;
	logic [W-1:0]     p_q;
	logic [NSTEP-1:0] sh_q;
	cmd_t             op_q;
	logic [7:0]       byte_q;
	logic             ovf_q;

	logic             fm_q;
	logic             ovf_out_q;
	logic [CW-1:0]    cnt_out_q;

	cmd_t             cmd;
	logic [CW-1:0]    last_idx;
	logic             star_ok;
	logic [W-1:0]     g_init;
	logic [W-1:0]     p_init;
	logic [XW-1:0]    cnt_x;

	assign cmd      = cmd_t'(in_cmd);
	assign last_idx = cnt_q - CW'(1);
	assign star_ok  = (in_byte == CH_STAR) && (cnt_q != '0) && !star_q[last_idx[IW-1:0]];

	// Seed vector and star propagate flags; bit j+1 belongs to element j.
	always_comb begin
		g_init    = '0;
		p_init    = '0;
		g_init[0] = (op_q != CMD_TEXT);
		for (int j = 0; j < MAX_ELEMENTS; j++) begin
			logic valid;
			logic hit;
			logic prev;
			valid = CW'(j) < cnt_q;
			hit   = (chars_q[j] == CH_ANY) || (chars_q[j] == byte_q);
			prev  = star_q[j] ? vec_q[j+1] : vec_q[j];
			p_init[j+1] = valid && star_q[j];
			if (op_q == CMD_TEXT) begin
				g_init[j+1] = valid && hit && prev;
			end
		end
	end

	assign status.last_step = sh_q[NSTEP-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			vec_q <= W'(1);
		end else begin
			if (ctl.accept) begin
				case (cmd)
					CMD_CLEAR: begin
						cnt_q <= '0;
					end
					CMD_APPEND: begin
						if (!star_ok && (cnt_q < CW'(MAX_ELEMENTS))) begin
							cnt_q <= cnt_q + CW'(1);
						end
					end
					default: begin
					end
				endcase
			end
			if (ctl.prep) begin
				vec_q <= g_init;
			end
			// one doubling of the star-run prefix per step
			if (ctl.step) begin
				vec_q <= vec_q | (p_q & (vec_q << sh_q));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			op_q   <= cmd;
			byte_q <= in_byte;
			ovf_q  <= 1'b0;
			if (cmd == CMD_APPEND) begin
				if (star_ok) begin
					star_q[last_idx[IW-1:0]] <= 1'b1;
				end else if (cnt_q < CW'(MAX_ELEMENTS)) begin
					chars_q[cnt_q[IW-1:0]] <= in_byte;
					star_q[cnt_q[IW-1:0]]  <= 1'b0;
				end else begin
					ovf_q <= 1'b1;
				end
			end
		end
		if (ctl.prep) begin
			p_q  <= p_init;
			sh_q <= NSTEP'(1);
		end
		if (ctl.step) begin
			p_q  <= p_q & (p_q << sh_q);
			sh_q <= sh_q << 1;
		end
		if (ctl.finish) begin
			fm_q      <= vec_q[cnt_q];
			ovf_out_q <= ovf_q;
			cnt_out_q <= cnt_q;
		end
	end

	assign cnt_x             = XW'(cnt_out_q);
	assign full_match        = fm_q;
	assign pattern_overflow  = ovf_out_q;
	assign element_count_out = cnt_x[COUNT_OUT_W-1:0];

	`include "dot_star_regex_matcher_core_assert.svh"

	`DSRM_ASSERT(a_count_bound, (cnt_q <= CW'(MAX_ELEMENTS)), "element count above store depth")

endmodule

@@ rtl/dot_star_regex_matcher_core.sv @@
// Whole-string matcher for patterns of literal bytes, '.' and '*', kept as
// up to MAX_ELEMENTS elements. Each input beat carries a command in tuser
// (clear pattern, append pattern byte, restart text, text byte) and a byte in
// tdata, and yields exactly one result beat: full match flag, overflow flag
// for a dropped append, and the element count. From acceptance an item
// passes through a prep state, the star-run closure and a finish state to
// the result register, and the next beat is taken only after that; the
// closure is a log-step prefix over the match vector that doubles its reach
// once per cycle. A finished result may wait on the output side while the
// next item is accepted.
module dot_star_regex_matcher_core
	import dsrm_pkg::*;
#(
	parameter int MAX_ELEMENTS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,  // [7:0] data_byte
	input  logic [1:0] s_tuser,  // [1:0] cmd
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata   // [0] full_match, [1] pattern_overflow,
	                             // [6:2] element_count_out, [7] zero
);

	dsrm_ctl_t              ctl;
	dsrm_status_t           status;
	logic                   full_match;
	logic                   pattern_overflow;
	logic [COUNT_OUT_W-1:0] element_count_out;

	dsrm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.ctl      (ctl)
	);

	dsrm_datapath #(
		.MAX_ELEMENTS (MAX_ELEMENTS)
	) u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.ctl               (ctl),
		.in_cmd            (s_tuser),
		.in_byte           (s_tdata),
		.status            (status),
		.full_match        (full_match),
		.pattern_overflow  (pattern_overflow),
		.element_count_out (element_count_out)
	);

	assign m_tdata = {1'b0, element_count_out, pattern_overflow, full_match};

endmodule
